[rtl/fsdss_pkg.sv]
package fsdss_pkg;

  // Command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam int NUM_POS        = 4;
  localparam int POINT_POS      = 2;
  localparam int BLANK_POS      = 3;
  localparam int VALUE_W        = 14;
  localparam int PAIR_W         = 7;
  localparam int PROD_W         = 27;
  localparam int RECIP_SHIFT    = 19;

  localparam logic [VALUE_W-1:0] VALUE_MAX  = 14'd9999;
  // floor(v * 5243 / 2**19) == floor(v / 100) for every v up to 9999
  localparam logic [PROD_W-1:0]  RECIP_100  = 27'd5243;
  localparam logic [6:0]         SEG_OFF    = 7'h7F;

  typedef logic [3:0] digit_t;
  typedef logic [1:0] pos_t;

  typedef struct packed {
    logic                cmd;
    logic signed [15:0]  value_hundredths;
  } in_item_t;

  typedef struct packed {
    logic [6:0] segments_n;
    logic [3:0] digit_enable;
    logic       point_n;
  } out_item_t;

  // Active-low segment pattern, bit 0 = A .. bit 6 = G
  function automatic logic [6:0] seg_pattern(input digit_t d);
    logic [6:0] seg;
    unique case (d)
      4'd0:    seg = 7'h40;
      4'd1:    seg = 7'h79;
      4'd2:    seg = 7'h24;
      4'd3:    seg = 7'h30;
      4'd4:    seg = 7'h19;
      4'd5:    seg = 7'h12;
      4'd6:    seg = 7'h02;
      4'd7:    seg = 7'h78;
      4'd8:    seg = 7'h00;
      4'd9:    seg = 7'h10;
      default: seg = SEG_OFF;
    endcase
    return seg;
  endfunction

  // Split a value below 100 into {tens, ones} with a compare ladder
  function automatic logic [7:0] split_pair(input logic [PAIR_W-1:0] x);
    digit_t              tens;
    logic [PAIR_W-1:0]   ones;
    tens = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (x >= PAIR_W'(k * 10)) begin
        tens = 4'(k);
      end
    end
    ones = x - PAIR_W'(tens) * PAIR_W'(10);
    return {tens, ones[3:0]};
  endfunction

endpackage

[rtl/fsdss_drive.sv]
module fsdss_drive
  import fsdss_pkg::*;
(
  input  pos_t      pos,
  input  digit_t    digit,
  output out_item_t drive
);

  always_comb begin
    // blank a leading zero in the tens place
    if (pos == pos_t'(BLANK_POS) && digit == 4'd0) begin
      drive.segments_n = SEG_OFF;
    end else begin
      drive.segments_n = seg_pattern(digit);
    end
    drive.digit_enable = 4'b0001 << pos;
    drive.point_n      = (pos == pos_t'(POINT_POS)) ? 1'b0 : 1'b1;
  end

endmodule

[rtl/four_digit_seven_segment_scanner.sv]
// Path: an accepted tick item passes the input register and the digit stage
//   before it lands in the output register.
// Throughput: one item per cycle while results are drained; a load produces
//   no result and never waits on the output itself, but queues behind a tick
//   that does, so at most three items are in flight.
// Reset (rst, synchronous): empties the pipeline, clears all four digits to
//   zero and returns the scan position to zero.
module four_digit_seven_segment_scanner
  import fsdss_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  // Stage A: raw input register
  logic      valid_a;
  in_item_t  item_a;

  // Stage B: clamped value and its hundreds quotient
  logic                valid_b;
  logic                cmd_b;
  logic [VALUE_W-1:0]  value_b;
  logic [PAIR_W-1:0]   quot_b;

  // Display state
  digit_t digit_store [NUM_POS];
  pos_t   scan_pos;

  logic                out_free;
  logic                a_move;
  logic                b_move;
  logic                load_fire;
  logic                tick_fire;
  logic [VALUE_W-1:0]  value_clamped;
  logic [PROD_W-1:0]   quot_prod;
  logic [VALUE_W-1:0]  rem_full;
  logic [7:0]          hi_pair;
  logic [7:0]          lo_pair;
  digit_t              rd_digit;
  out_item_t           drive;

  // The output slot can take a new result when empty or being drained.
  // A load in stage B always retires; a tick needs the output slot.
  assign out_free  = !out_valid || out_ready;
  assign b_move    = !valid_b || (cmd_b == CMD_LOAD) || out_free;
  assign a_move    = !valid_a || b_move;
  assign in_ready  = a_move;
  assign load_fire = valid_b && (cmd_b == CMD_LOAD);
  assign tick_fire = valid_b && (cmd_b == CMD_TICK) && out_free;

  // Stage A logic: clamp negatives to zero and large values to 99.99,
  // then take the hundreds quotient by reciprocal multiply.
  always_comb begin
    if (item_a.value_hundredths[15]) begin
      value_clamped = '0;
    end else if (item_a.value_hundredths[14:0] > 15'(VALUE_MAX)) begin
      value_clamped = VALUE_MAX;
    end else begin
      value_clamped = item_a.value_hundredths[VALUE_W-1:0];
    end
    quot_prod = PROD_W'(value_clamped) * RECIP_100;
  end

  // Stage B logic: remainder below 100, then both pairs to decimal digits
  always_comb begin
    rem_full = value_b - VALUE_W'(quot_b) * VALUE_W'(100);
    hi_pair  = split_pair(quot_b);
    lo_pair  = split_pair(rem_full[PAIR_W-1:0]);
  end

  // Ticks read the store after every earlier load has written it,
  // since both kinds of item pass stage B in order.
  assign rd_digit = digit_store[scan_pos];

  fsdss_drive u_drive (
    .pos   (scan_pos),
    .digit (rd_digit),
    .drive (drive)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a     <= 1'b0;
      valid_b     <= 1'b0;
      out_valid   <= 1'b0;
      scan_pos    <= '0;
      digit_store <= '{default: '0};
    end else begin
      if (a_move) begin
        valid_a <= in_valid;
      end
      if (b_move) begin
        valid_b <= valid_a;
      end
      if (tick_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      // Least significant digit first
      if (load_fire) begin
        digit_store[0] <= lo_pair[3:0];
        digit_store[1] <= lo_pair[7:4];
        digit_store[2] <= hi_pair[3:0];
        digit_store[3] <= hi_pair[7:4];
      end
      // Advance the scan, wrapping after the tens digit
      if (tick_fire) begin
        scan_pos <= scan_pos + pos_t'(1);
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (a_move) begin
      item_a <= in_item;
    end
    if (b_move) begin
      cmd_b   <= item_a.cmd;
      value_b <= value_clamped;
      quot_b  <= quot_prod[RECIP_SHIFT +: PAIR_W];
    end
    if (tick_fire) begin
      out_item <= drive;
    end
  end

  // Exactly one digit is enabled on every result
  a_onehot_enable: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot(out_item.digit_enable))
    else $error("digit enable not one-hot");

  // The point is lit only together with position 2
  a_point_pos: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_item.point_n) |-> out_item.digit_enable[POINT_POS])
    else $error("decimal point lit off position 2");

  // A scanned digit is always decimal
  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    (valid_b && cmd_b == CMD_TICK) |-> (rd_digit <= 4'd9))
    else $error("stored digit above 9");

  // Each emitted tick advances the scan position by one
  a_scan_step: assert property (@(posedge clk) disable iff (rst)
    tick_fire |=> (scan_pos == $past(scan_pos) + pos_t'(1)))
    else $error("scan position did not advance");

endmodule

[sim/four_digit_seven_segment_scanner_tb.sv]
`timescale 1ns / 1ps

import fsdss_pkg::*;

// Tracks the digit store and scan position of the display and holds the
// drives that the block still owes.
class display_scoreboard;
  digit_t    digits[NUM_POS];
  pos_t      scan_pos;
  out_item_t drive_queue[$];
  int        error_count;

  // Active-low patterns for 0..9, bit 0 = A .. bit 6 = G
  logic [6:0] glyph[10] = '{7'h40, 7'h79, 7'h24, 7'h30, 7'h19,
                            7'h12, 7'h02, 7'h78, 7'h00, 7'h10};

  function new();
    foreach (digits[i]) digits[i] = '0;
    scan_pos    = '0;
    error_count = 0;
  endfunction

  function int pending();
    return drive_queue.size();
  endfunction

  task report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    error_count++;
  endtask

  // Note an accepted input item: a load updates the digits, a tick owes a drive.
  function void note_item(input in_item_t it);
    int        v;
    digit_t    d;
    out_item_t drv;
    if (it.cmd == CMD_LOAD) begin
      v = int'(it.value_hundredths);
      if (v < 0) v = 0;
      else if (v > 9999) v = 9999;
      for (int i = 0; i < NUM_POS; i++) begin
        digits[i] = digit_t'(v % 10);
        v = v / 10;
      end
    end else begin
      d = digits[scan_pos];
      if ((int'(scan_pos) == BLANK_POS && d == 0) || d > 9) drv.segments_n = SEG_OFF;
      else drv.segments_n = glyph[d];
      drv.digit_enable = 4'b0001 << scan_pos;
      drv.point_n      = (int'(scan_pos) == POINT_POS) ? 1'b0 : 1'b1;
      drive_queue.push_back(drv);
      scan_pos = scan_pos + 1'b1;
    end
  endfunction

  // Compare one accepted drive with the oldest one owed.
  task check_drive(input out_item_t got);
    out_item_t want;
    if (drive_queue.size() == 0) begin
      report_mismatch($sformatf("drive %h with nothing owed", got));
    end else begin
      want = drive_queue.pop_front();
      if (got.segments_n !== want.segments_n)
        report_mismatch($sformatf("segments_n %h, want %h", got.segments_n, want.segments_n));
      if (got.digit_enable !== want.digit_enable)
        report_mismatch($sformatf("digit_enable %h, want %h",
                                  got.digit_enable, want.digit_enable));
      if (got.point_n !== want.point_n)
        report_mismatch($sformatf("point_n %b, want %b", got.point_n, want.point_n));
    end
  endtask
endclass

module four_digit_seven_segment_scanner_tb;
  // Generous bound: the slowest correct run stays far below this.
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_ITEMS = 1880;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_item;

  display_scoreboard sb;
  bit hold_off_req;
  int cycle_count = 0;

  four_digit_seven_segment_scanner dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  // 10 ns clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Watchdog: end the run if the drives never catch up.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Check every drive that the display side accepts.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_drive(out_item);
  end

  // Receiver: a stall pattern of its own that picks a new random mode at the
  // start of each phase, plus one long hold-off on request.
  initial begin : receiver
    int mode;
    int phase_cnt;
    out_ready = 1'b0;
    mode      = 0;
    phase_cnt = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        // Hold ready low so the pipeline fills and stalls the input side.
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end else begin
        if (phase_cnt == 0) mode = $urandom_range(0, 3);
        phase_cnt = (phase_cnt + 1) % 64;
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 1) == 0);
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= (phase_cnt % 3 == 0);
        endcase
      end
    end
  end

  // Offer one item and hold it until the block takes it.
  task automatic send_item(input in_item_t it);
    @(negedge clk);
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_item(it);
  endtask

  // Hold valid low for n idle steps; the payload is noise meanwhile.
  task automatic idle_cycles(input int n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
      in_item  <= {1'($urandom), 16'($urandom)};
    end
  endtask

  // Stop offering and wait until every owed drive has come out.
  task automatic drain();
    idle_cycles(1);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic in_item_t make_load(input int v);
    in_item_t it;
    it.cmd              = CMD_LOAD;
    it.value_hundredths = 16'(v);
    return it;
  endfunction

  function automatic in_item_t make_tick();
    in_item_t it;
    it.cmd              = CMD_TICK;
    it.value_hundredths = 16'($urandom);  // ignored on a tick
    return it;
  endfunction

  // Ticks dominate; load values lean on the clamp edges and on values that
  // leave the tens digit zero.
  function automatic in_item_t random_item();
    int v;
    if ($urandom_range(0, 99) < 65) return make_tick();
    case ($urandom_range(0, 9))
      0: v = -int'($urandom_range(1, 32768));
      1: v = $urandom_range(10000, 32767);
      2: v = $urandom_range(0, 999);
      3: begin
        case ($urandom_range(0, 5))
          0: v = 0;
          1: v = 9999;
          2: v = 10000;
          3: v = -1;
          4: v = 32767;
          default: v = -32768;
        endcase
      end
      default: v = $urandom_range(0, 9999);
    endcase
    return make_load(v);
  endfunction

  // Random items in bursts of random length with random gaps.
  task automatic random_phase(input int count);
    int sent;
    int burst;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst && sent < count; k++) begin
        send_item(random_item());
        sent++;
      end
      if ($urandom_range(0, 3) == 0) idle_cycles(0);
      else idle_cycles($urandom_range(1, 6));
    end
  endtask

  task automatic ticks(input int n);
    repeat (n) send_item(make_tick());
  endtask

  initial begin : stimulus
    sb           = new();
    hold_off_req = 1'b0;
    rst          = 1'b1;
    in_valid     = 1'b0;
    in_item      = '0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // Directed: scan from reset, clamp edges, blanking and position hold.
    ticks(4);                        // reset digits: blank tens, point on 2
    send_item(make_load(1234));
    ticks(4);
    send_item(make_load(9999));
    ticks(2);
    send_item(make_load(-1));        // negative clamps to zero
    ticks(2);                        // load must not move the scan position
    send_item(make_load(32767));     // above range clamps to 99.99
    ticks(1);
    send_item(make_load(-32768));
    send_item(make_load(10000));
    ticks(1);
    send_item(make_load(5678));
    send_item(make_load(905));       // tens and tenths digits zero, others not
    ticks(1);
    drain();

    random_phase(RANDOM_ITEMS / 3);

    // Long hold-off on the display side while items keep coming.
    drain();
    hold_off_req = 1'b1;
    send_item(make_load($urandom_range(1000, 9999)));
    ticks(60);
    drain();

    random_phase(RANDOM_ITEMS - RANDOM_ITEMS / 3 - 61);

    drain();
    repeat (20) @(posedge clk);
    if (sb.error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
